/* rtl/cross_neighbourhood_sum_threshold_macros.svh */
// assertion macros for the cross neighbourhood sum threshold block
// used by the top level; expects signals clk and rst_n in scope
`ifndef CROSS_NEIGHBOURHOOD_SUM_THRESHOLD_MACROS_SVH
`define CROSS_NEIGHBOURHOOD_SUM_THRESHOLD_MACROS_SVH

// same-cycle implication, disabled during reset
`define CNST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CNST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cnst_pkg.sv */
// shared types and constants for the cross neighbourhood sum threshold block
// no dependencies; imported by every module of the block
package cnst_pkg;

  // fixed field widths
  localparam int CFG_W    = 11;
  localparam int COORD_W  = 10;
  localparam int PIX_IN_W = 8;
  localparam int CFG_IDX_W = 2;

  // default parameter values
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_THRESH = 11'd30;
  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd8;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd6;

  // smallest frame dimension in use
  localparam int MIN_DIM = 3;

  // configuration register set
  typedef struct packed {
    logic [CFG_W-1:0] thresh;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cnst_cfg_t;

  // per-pixel control travelling down the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               emit;
    logic               last;
  } cnst_item_t;

endpackage

/* rtl/cnst_cfg_regs.sv */
// configuration register file: threshold, frame width and frame height
// depends on cnst_pkg
module cnst_cfg_regs
  import cnst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cnst_cfg_t            cfg
);

  cnst_cfg_t cfg_r;
  cnst_cfg_t cfg_nxt;

  // decode register index, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_IDX_THRESH: cfg_nxt.thresh = wr_data;
        CFG_IDX_WIDTH:  cfg_nxt.width  = wr_data;
        CFG_IDX_HEIGHT: cfg_nxt.height = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh <= RST_THRESH;
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/cnst_raster_pos.sv */
// raster position tracker and result decode for each incoming pixel
// depends on cnst_pkg; frame size comes from the configuration registers
module cnst_raster_pos
  import cnst_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CCW = $clog2(MAX_WIDTH),
  localparam int RCW = $clog2(MAX_HEIGHT)
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            frame_start,
  input  cnst_cfg_t       cfg,
  output cnst_item_t      item,
  output logic [CCW-1:0]  col_addr
);

  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (WCW > CFG_W) ? WCW : CFG_W;
  localparam int CWH = (HCW > CFG_W) ? HCW : CFG_W;

  logic [CCW-1:0] col_r, col_nxt;
  logic [RCW-1:0] row_r, row_nxt;
  logic [CCW-1:0] c;
  logic [RCW-1:0] r;
  logic [CWW-1:0] w_ext;
  logic [CWH-1:0] h_ext;
  logic [WCW-1:0] w_cl;
  logic [HCW-1:0] h_cl;
  logic [WCW:0]   c_p1, c_p2, w_cmp;
  logic [HCW:0]   r_cmp, r_p1, h_cmp;

  // clamp frame size into the supported range
  always_comb begin
    w_ext = CWW'(cfg.width);
    h_ext = CWH'(cfg.height);
    if (w_ext < CWW'(MIN_DIM)) w_cl = WCW'(MIN_DIM);
    else if (w_ext > CWW'(MAX_WIDTH)) w_cl = WCW'(MAX_WIDTH);
    else w_cl = WCW'(w_ext);
    if (h_ext < CWH'(MIN_DIM)) h_cl = HCW'(MIN_DIM);
    else if (h_ext > CWH'(MAX_HEIGHT)) h_cl = HCW'(MAX_HEIGHT);
    else h_cl = HCW'(h_ext);
  end

  // position of this pixel, frame start restarts at the origin
  assign c = frame_start ? '0 : col_r;
  assign r = frame_start ? '0 : row_r;

  assign c_p1  = (WCW+1)'(c) + (WCW+1)'(1);
  assign c_p2  = (WCW+1)'(c) + (WCW+1)'(2);
  assign w_cmp = (WCW+1)'(w_cl);
  assign r_cmp = (HCW+1)'(r);
  assign r_p1  = (HCW+1)'(r) + (HCW+1)'(1);
  assign h_cmp = (HCW+1)'(h_cl);

  // judge the centre one row up when it is an interior cell
  always_comb begin
    item.emit    = (r_cmp >= (HCW+1)'(2)) && (r_cmp < h_cmp) &&
                   (c != '0) && (c_p2 <= w_cmp);
    item.last    = (r_p1 == h_cmp) && (c_p2 == w_cmp);
    item.out_row = COORD_W'(r - RCW'(1));
    item.out_col = COORD_W'(c);
  end

  assign col_addr = c;

  // advance position, wrapping at row and frame end
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (c_p1 >= w_cmp) begin
        col_nxt = '0;
        row_nxt = (r_p1 >= h_cmp) ? '0 : RCW'(r_p1);
      end else begin
        col_nxt = CCW'(c_p1);
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/cnst_line_bufs.sv */
// two line stores holding the previous row and the row before it
// depends on cnst_pkg; registered reads, one write per store per cycle
module cnst_line_bufs
  import cnst_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int PB    = PIX_IN_W,
  localparam int AW   = $clog2(DEPTH)
)
(
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [PB-1:0] px_wdata,
  input  logic          wr2_en,
  input  logic [AW-1:0] wr2_addr,
  input  logic [PB-1:0] wr2_data,
  output logic [PB-1:0] up_q,
  output logic [PB-1:0] right_q,
  output logic [PB-1:0] up2_q
);

  logic [PB-1:0] prev_mem  [DEPTH];
  logic [PB-1:0] prev2_mem [DEPTH];
  logic [AW-1:0] right_addr;

  // right neighbour sits one column on, wrapping at the store depth
  assign right_addr = (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);

  // previous row: read centre and right, write the new pixel in its place
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q              <= prev_mem[rd_addr];
      right_q           <= prev_mem[right_addr];
      prev_mem[rd_addr] <= px_wdata;
    end
  end

  // row before: read above-centre, written one stage later with the old centre
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up2_q <= prev2_mem[rd_addr];
    end
    if (wr2_en) begin
      prev2_mem[wr2_addr] <= wr2_data;
    end
  end

endmodule

/* rtl/cross_neighbourhood_sum_threshold.sv */
// Five-point cross sum threshold over a raster pixel stream.
// Input channel in_*: one pixel per request, in_tdata[7:0] = pixel,
// in_tuser = frame start (puts the pixel at row 0, column 0).
// Output channel out_*: one request per interior centre pixel, sent when
// the pixel below it arrives; out_tdata = {above flag, column, row},
// out_tlast marks the last interior result of the frame.
// Config channel cfg_*: index 0 threshold, 1 width, 2 height; always ready.
// It is to be written only while the block is idle; the block itself does not enforce this.
// Throughput: one pixel per clock while in_tready is high; each line store takes
// one write per cycle, the previous-row store two reads and the row before one.
// A result shows on out_tvalid from the output register, after the pixel that
// completes it passes the input register and the line store read register.
// Pixels that produce no result drop out before the output register, so the
// input keeps moving while a result waits; in_tready falls only when all
// three stages are full and the receiver holds off.
// Reset: position returns to row 0, column 0, registers take their defaults,
// pipeline empties; line store contents are not cleared.
// depends on cnst_pkg, cnst_cfg_regs, cnst_raster_pos, cnst_line_bufs
`include "cross_neighbourhood_sum_threshold_macros.svh"

module cross_neighbourhood_sum_threshold
  import cnst_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input pixels
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] pixel
  input  logic                 in_tuser,   // [0] frame_start
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [9:0] out_row, [19:10] out_col,
                                           // [20] above_flag, [23:21] zero
  output logic                 out_tlast,  // frame_last
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CCW = $clog2(MAX_WIDTH);
  localparam int PB  = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int SW  = PB + 3;

  cnst_cfg_t      cfg;
  cnst_item_t     in_item;
  logic [CCW-1:0] in_addr;
  logic           in_acc;
  logic           a_move, b_move;

  logic           a_valid_r;
  cnst_item_t     a_item_r;
  logic [CCW-1:0] a_addr_r;
  logic [PB-1:0]  a_px_r;

  logic           b_valid_r;
  cnst_item_t     b_item_r;
  logic [CCW-1:0] b_addr_r;
  logic [PB-1:0]  b_px_r;

  logic [PB-1:0]  up_q, right_q, up2_q;
  logic [PB-1:0]  left_r;
  logic [SW-1:0]  sum;
  logic           above;

  logic           c_valid_r;
  cnst_item_t     c_item_r;
  logic           c_above_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  cnst_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // raster position of the incoming pixel
  cnst_raster_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .frame_start (in_tuser),
    .cfg         (cfg),
    .item        (in_item),
    .col_addr    (in_addr)
  );

  // stage flow: pixels without a result leave stage b without the output
  assign b_move    = b_valid_r && (!b_item_r.emit || !c_valid_r || out_tready);
  assign a_move    = a_valid_r && (!b_valid_r || b_move);
  assign in_tready = !a_valid_r || a_move;
  assign in_acc    = in_tvalid && in_tready;

  // stage a: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_item_r <= in_item;
      a_addr_r <= in_addr;
      a_px_r   <= in_tdata[PB-1:0];
    end
  end

  // line stores, read as the pixel moves into stage b
  cnst_line_bufs #(
    .DEPTH (MAX_WIDTH),
    .PB    (PB)
  ) u_lines (
    .clk      (clk),
    .rd_en    (a_move),
    .rd_addr  (a_addr_r),
    .px_wdata (a_px_r),
    .wr2_en   (b_move),
    .wr2_addr (b_addr_r),
    .wr2_data (up_q),
    .up_q     (up_q),
    .right_q  (right_q),
    .up2_q    (up2_q)
  );

  // stage b: line store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
    end else if (b_move) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_item_r <= a_item_r;
      b_addr_r <= a_addr_r;
      b_px_r   <= a_px_r;
    end
  end

  // cross sum and threshold compare
  assign sum   = SW'(up_q) + SW'(up2_q) + SW'(left_r) + SW'(right_q) + SW'(b_px_r);
  assign above = CFG_W'(sum) > cfg.thresh;

  // left neighbour of the next centre is this centre
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (b_move) begin
      left_r <= up_q;
    end
  end

  // stage c: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (b_move && b_item_r.emit) begin
      c_valid_r <= 1'b1;
    end else if (out_tready) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move && b_item_r.emit) begin
      c_item_r  <= b_item_r;
      c_above_r <= above;
    end
  end

  assign out_tvalid = c_valid_r;
  assign out_tdata  = {3'b000, c_above_r, c_item_r.out_col, c_item_r.out_row};
  assign out_tlast  = c_item_r.last;

  // checks
  `CNST_ASSERT_NOW(a_stall_full, !in_tready, a_valid_r && b_valid_r && c_valid_r && !out_tready, "input stalled while pipeline not full")
  `CNST_ASSERT_NEXT(a_emit_lands, b_move && b_item_r.emit, c_valid_r, "result lost between stage b and output")
  `CNST_ASSERT_NEXT(a_frame_origin, in_acc && in_tuser, a_valid_r && (a_addr_r == '0) && !a_item_r.emit, "frame start did not restart at origin")

endmodule
